>>> rtl/core/rfid_rx_pkg.sv
// Package for the RFID frame receiver: constants, microcode types and the control store.
package rfid_rx_pkg;

   localparam int FRAME_BYTES  = 14;
   localparam int ID_CHARS_DEF = 10;
   localparam int ID_PAIRS     = 5;

   localparam logic [7:0] STOP_VALUE  = 8'd3;
   localparam logic [7:0] START_RESET = 8'd2;

   // Fixed store positions used by the check
   localparam logic [3:0] POS_SUM_HI = 4'd11;
   localparam logic [3:0] POS_SUM_LO = 4'd12;
   localparam logic [3:0] POS_STOP   = 4'(FRAME_BYTES - 1);
   localparam logic [3:0] LAST_PAIR  = 4'(ID_PAIRS - 1);

   // Datapath operation of one microcode step
   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_STOP,
      OP_HI,
      OP_LO,
      OP_SUM_HI,
      OP_SUM_LO,
      OP_EMIT_ID
   } op_type;

   // Jump condition of one microcode step
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_CHECK,
      COND_BAD_STOP,
      COND_MORE_PAIRS,
      COND_SUM_BAD,
      COND_MORE_ID
   } cond_type;

   typedef struct packed {
      op_type     op;
      logic       emit_status;
      cond_type   cond;
      logic [3:0] target;
   } ucode_type;

   // Step addresses
   localparam logic [3:0] STEP_FETCH  = 4'd0;
   localparam logic [3:0] STEP_STOP   = 4'd1;
   localparam logic [3:0] STEP_HI     = 4'd2;
   localparam logic [3:0] STEP_LO     = 4'd3;
   localparam logic [3:0] STEP_SUM_HI = 4'd4;
   localparam logic [3:0] STEP_SUM_LO = 4'd5;
   localparam logic [3:0] STEP_EMIT   = 4'd6;
   localparam logic [3:0] STEP_DONE   = 4'd7;
   localparam logic [3:0] STEP_STATUS = 4'd8;

   // Control store: jump to target when the condition holds, else advance
   function automatic ucode_type ucode_rom(input logic [3:0] step);
      ucode_type w;
      w = '{op: OP_NOP, emit_status: 1'b0, cond: COND_ALWAYS, target: STEP_FETCH};
      case (step)
         STEP_FETCH:  w = '{OP_ACCEPT,  1'b0, COND_NO_CHECK,   STEP_STATUS};
         STEP_STOP:   w = '{OP_STOP,    1'b0, COND_BAD_STOP,   STEP_STATUS};
         STEP_HI:     w = '{OP_HI,      1'b0, COND_NEVER,      STEP_FETCH};
         STEP_LO:     w = '{OP_LO,      1'b0, COND_MORE_PAIRS, STEP_HI};
         STEP_SUM_HI: w = '{OP_SUM_HI,  1'b0, COND_NEVER,      STEP_FETCH};
         STEP_SUM_LO: w = '{OP_SUM_LO,  1'b0, COND_SUM_BAD,    STEP_STATUS};
         STEP_EMIT:   w = '{OP_EMIT_ID, 1'b0, COND_MORE_ID,    STEP_EMIT};
         STEP_DONE:   w = '{OP_NOP,     1'b0, COND_ALWAYS,     STEP_FETCH};
         STEP_STATUS: w = '{OP_NOP,     1'b1, COND_ALWAYS,     STEP_FETCH};
         default:     w = '{OP_NOP,     1'b0, COND_ALWAYS,     STEP_FETCH};
      endcase
      return w;
   endfunction

   // ASCII hex digit to value; other characters pass through
   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = c;
      if (c inside {["0":"9"]}) begin
         v = c - 8'd48;
      end else if (c inside {["A":"F"]}) begin
         v = c - 8'd55;
      end
      return v;
   endfunction

endpackage

>>> rtl/core/rfid_ascii_frame_receiver_unit.sv
// Top level of the RFID frame receiver: microcoded sequencer, frame store and result register.
//
//   channel  | ports                                        | direction
//   ---------+----------------------------------------------+----------
//   request  | req_valid/req_ready, req_func, req_rx_byte   | in
//   response | rsp_valid/rsp_ready, rsp_carries_id, ...     | out
//   config   | csr_wr_en, csr_wr_data (start byte)          | in
//
// An item that gives a status result runs the fetch step, then the status step.
// A closing byte with the flag clear runs the check, one store read per step: fetch and stop
// steps, a HI and a LO step per ID pair (five pairs), two checksum steps, then ID_CHARS emit
// steps and one return step; a failed check ends at once with one status step instead.
// Reset (synchronous) clears the sequencer, frame tracking and flag, start byte back to 2.
// Emit and status steps hold while the result register is full and not taken; the
// request side is ready only in the fetch step.
module rfid_ascii_frame_receiver_unit
   import rfid_rx_pkg::*;
#(
   parameter int ID_CHARS = ID_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_carries_id,
   output logic       rsp_card_ready,
   output logic [7:0] rsp_id_char,
   output logic [3:0] rsp_id_index,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam logic [3:0] LAST_ID = 4'(ID_CHARS - 1);

   // Control and datapath registers
   logic [3:0]  step_ff, step_in;
   logic [3:0]  k_ff, k_in;
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  hi_ff, hi_in;
   logic        in_frame_ff, in_frame_in;
   logic [3:0]  pos_ff, pos_in;
   logic        ready_flag_ff, ready_flag_in;
   logic [7:0]  start_byte_ff, start_byte_in;
   logic [7:0]  store_ff [FRAME_BYTES];
   logic [7:0]  store_in [FRAME_BYTES];

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_carries_id_ff, rsp_carries_id_in;
   logic        rsp_card_ready_ff, rsp_card_ready_in;
   logic [7:0]  rsp_id_char_ff, rsp_id_char_in;
   logic [3:0]  rsp_id_index_ff, rsp_id_index_in;
   logic        rsp_last_ff, rsp_last_in;

   ucode_type   uw;
   logic        slot_free;
   logic        fire;
   logic        jump;
   logic [3:0]  rd_addr;
   logic [7:0]  rd_data;
   logic [7:0]  rd_hex;
   logic [11:0] given;
   logic        closing;
   logic [3:0]  wr_pos;

   assign uw        = ucode_rom(step_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (uw.op == OP_ACCEPT);

   // Step fires when its handshake side can move
   always_comb begin
      if (uw.op == OP_ACCEPT) begin
         fire = req_valid;
      end else if (uw.op == OP_EMIT_ID || uw.emit_status) begin
         fire = slot_free;
      end else begin
         fire = 1'b1;
      end
   end

   // Select the one store entry read this step
   always_comb begin
      case (uw.op)
         OP_STOP:    rd_addr = POS_STOP;
         OP_HI:      rd_addr = 4'({k_ff[2:0], 1'b0}) + 4'd1;
         OP_LO:      rd_addr = 4'({k_ff[2:0], 1'b0}) + 4'd2;
         OP_SUM_HI:  rd_addr = POS_SUM_HI;
         OP_SUM_LO:  rd_addr = POS_SUM_LO;
         OP_EMIT_ID: rd_addr = k_ff + 4'd1;
         default:    rd_addr = POS_STOP;
      endcase
   end

   assign rd_data = store_ff[rd_addr];
   assign rd_hex  = hex_value(rd_data);
   assign given   = {hi_ff, 4'b0000} | {4'b0000, rd_hex};

   // Position of a byte inside a frame
   assign wr_pos  = (pos_ff < POS_STOP) ? pos_ff + 4'd1 : pos_ff;
   assign closing = !req_func && in_frame_ff && (wr_pos >= POS_STOP);

   // Evaluate the jump condition
   always_comb begin
      case (uw.cond)
         COND_NEVER:      jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_NO_CHECK:   jump = !(closing && !ready_flag_ff);
         COND_BAD_STOP:   jump = (rd_data != STOP_VALUE);
         COND_MORE_PAIRS: jump = (k_ff != LAST_PAIR);
         COND_SUM_BAD:    jump = (given != {4'b0000, acc_ff});
         COND_MORE_ID:    jump = (k_ff != LAST_ID);
         default:         jump = 1'b0;
      endcase
   end

   // Datapath and sequencer next state
   always_comb begin
      step_in           = step_ff;
      k_in              = k_ff;
      acc_in            = acc_ff;
      hi_in             = hi_ff;
      in_frame_in       = in_frame_ff;
      pos_in            = pos_ff;
      ready_flag_in     = ready_flag_ff;
      start_byte_in     = csr_wr_en ? csr_wr_data : start_byte_ff;
      store_in          = store_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_carries_id_in = rsp_carries_id_ff;
      rsp_card_ready_in = rsp_card_ready_ff;
      rsp_id_char_in    = rsp_id_char_ff;
      rsp_id_index_in   = rsp_id_index_ff;
      rsp_last_in       = rsp_last_ff;

      if (fire) begin
         step_in = jump ? uw.target : step_ff + 4'd1;
         case (uw.op)
            OP_ACCEPT: begin
               if (req_func) begin
                  ready_flag_in = 1'b0;
               end else if (!in_frame_ff && req_rx_byte == start_byte_ff) begin
                  in_frame_in = 1'b1;
                  pos_in      = 4'd0;
                  store_in[0] = req_rx_byte;
               end else if (in_frame_ff) begin
                  pos_in           = wr_pos;
                  store_in[wr_pos] = req_rx_byte;
                  if (wr_pos >= POS_STOP) begin
                     in_frame_in = 1'b0;
                  end
               end
            end
            OP_STOP: begin
               k_in   = 4'd0;
               acc_in = 8'd0;
            end
            OP_HI: begin
               hi_in = rd_hex;
            end
            OP_LO: begin
               acc_in = acc_ff ^ ({hi_ff[3:0], 4'b0000} | rd_hex);
               k_in   = k_ff + 4'd1;
            end
            OP_SUM_HI: begin
               hi_in = rd_hex;
            end
            OP_SUM_LO: begin
               k_in = 4'd0;
               if (!jump) begin
                  ready_flag_in = 1'b1;
               end
            end
            OP_EMIT_ID: begin
               rsp_valid_in      = 1'b1;
               rsp_carries_id_in = 1'b1;
               rsp_card_ready_in = ready_flag_ff;
               rsp_id_char_in    = rd_data;
               rsp_id_index_in   = k_ff;
               rsp_last_in       = (k_ff == LAST_ID);
               k_in              = k_ff + 4'd1;
            end
            default: begin
            end
         endcase
         // Status result for every item that emits no ID run
         if (uw.emit_status) begin
            rsp_valid_in      = 1'b1;
            rsp_carries_id_in = 1'b0;
            rsp_card_ready_in = ready_flag_ff;
            rsp_id_char_in    = 8'd0;
            rsp_id_index_in   = 4'd0;
            rsp_last_in       = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_FETCH;
         in_frame_ff   <= 1'b0;
         pos_ff        <= 4'd0;
         ready_flag_ff <= 1'b0;
         start_byte_ff <= START_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         in_frame_ff   <= in_frame_in;
         pos_ff        <= pos_in;
         ready_flag_ff <= ready_flag_in;
         start_byte_ff <= start_byte_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff              <= k_in;
      acc_ff            <= acc_in;
      hi_ff             <= hi_in;
      store_ff          <= store_in;
      rsp_carries_id_ff <= rsp_carries_id_in;
      rsp_card_ready_ff <= rsp_card_ready_in;
      rsp_id_char_ff    <= rsp_id_char_in;
      rsp_id_index_ff   <= rsp_id_index_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // Drive the response port
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_carries_id = rsp_carries_id_ff;
   assign rsp_card_ready = rsp_card_ready_ff;
   assign rsp_id_char    = rsp_id_char_ff;
   assign rsp_id_index   = rsp_id_index_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> dv/tb_rfid_ascii_frame_receiver_unit.sv
// Testbench for the RFID ASCII frame receiver: framed byte stimulus, frame prediction, checks.
module tb_rfid_ascii_frame_receiver_unit;
   import rfid_rx_pkg::*;

   localparam int NUM_ID        = ID_CHARS_DEF;
   localparam int ID_LEN        = 2 * ID_PAIRS;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASE_ITEMS   = 60;
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;

   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } reader_item_type;

   typedef struct packed {
      logic       carries_id;
      logic       card_ready;
      logic [7:0] id_char;
      logic [3:0] id_index;
      logic       last;
   } card_result_type;

   typedef enum {
      FRM_GOOD,
      FRM_FIXED,
      FRM_ODD_ID,
      FRM_BAD_SUM,
      FRM_BAD_STOP,
      FRM_RAW_SUM,
      FRM_SHORT
   } frame_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = 1'b0;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_carries_id;
   logic       rsp_card_ready;
   logic [7:0] rsp_id_char;
   logic [3:0] rsp_id_index;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   // Stimulus and expectation stores
   reader_item_type byte_queue[$];
   card_result_type due_results[$];
   int           items_queued = 0;
   int           items_taken = 0;
   int           results_seen = 0;
   int           error_count = 0;
   int           cycle_count = 0;
   int           tx_gap_pct = 0;
   int           rx_stall_pct = 0;
   logic [7:0]   frame_id[ID_LEN];

   // Predicted receiver state
   logic       trk_in_frame;
   logic [3:0] trk_pos;
   logic [7:0] trk_store[FRAME_BYTES];
   logic       trk_card_ready;
   logic [7:0] trk_start_byte;

   rfid_ascii_frame_receiver_unit #(
      .ID_CHARS(NUM_ID)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_carries_id (rsp_carries_id),
      .rsp_card_ready (rsp_card_ready),
      .rsp_id_char    (rsp_id_char),
      .rsp_id_index   (rsp_id_index),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decode one ASCII hex digit; anything else passes through as is
   function automatic logic [7:0] hex_to_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return c - 8'd48;
      end
      if (c >= "A" && c <= "F") begin
         return c - 8'd55;
      end
      return c;
   endfunction

   function automatic logic [7:0] nibble_to_hex(input logic [3:0] n);
      return (n < 4'd10) ? 8'd48 + n : 8'd55 + n;
   endfunction

   // XOR of the ID bytes, each built from a pair of decoded characters
   function automatic logic [7:0] id_xor(input logic [7:0] chars[ID_LEN]);
      logic [7:0] xsum;
      logic [7:0] hi;
      logic [7:0] lo;
      xsum = 8'd0;
      for (int k = 0; k < ID_PAIRS; k++) begin
         hi = hex_to_nibble(chars[2 * k]);
         lo = hex_to_nibble(chars[2 * k + 1]);
         xsum ^= {hi[3:0], 4'h0} | lo;
      end
      return xsum;
   endfunction

   function automatic logic stored_frame_ok();
      logic [7:0]  ids[ID_LEN];
      logic [11:0] given;
      for (int k = 0; k < ID_LEN; k++) begin
         ids[k] = trk_store[1 + k];
      end
      given = {hex_to_nibble(trk_store[POS_SUM_HI]), 4'h0}
            | {4'h0, hex_to_nibble(trk_store[POS_SUM_LO])};
      return trk_store[POS_STOP] == STOP_VALUE && given == {4'h0, id_xor(ids)};
   endfunction

   // Advance the frame tracker by one transfer and queue what it should produce
   task automatic parse_reader_byte(input reader_item_type itm);
      card_result_type res;
      if (itm.func == FUNC_CLEAR) begin
         trk_card_ready = 1'b0;
      end else if (!trk_in_frame && itm.rx_byte == trk_start_byte) begin
         trk_in_frame = 1'b1;
         trk_pos = 4'd0;
         trk_store[0] = itm.rx_byte;
      end else if (trk_in_frame) begin
         if (trk_pos < POS_STOP) begin
            trk_pos++;
         end
         trk_store[trk_pos] = itm.rx_byte;
         if (trk_pos >= POS_STOP) begin
            trk_in_frame = 1'b0;
            if (!trk_card_ready && stored_frame_ok()) begin
               trk_card_ready = 1'b1;
               for (int k = 0; k < NUM_ID; k++) begin
                  res.carries_id = 1'b1;
                  res.card_ready = 1'b1;
                  res.id_char    = trk_store[1 + k];
                  res.id_index   = 4'(k);
                  res.last       = (k == NUM_ID - 1);
                  due_results.push_back(res);
               end
               return;
            end
         end
      end
      res.carries_id = 1'b0;
      res.card_ready = trk_card_ready;
      res.id_char    = 8'd0;
      res.id_index   = 4'd0;
      res.last       = 1'b1;
      due_results.push_back(res);
   endtask

   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Request driver: hold each item until its transfer, then space the next one
   int   tx_gap = 0;
   logic tx_free;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap    <= 0;
      end else begin
         tx_free = !req_valid;
         if (req_valid && req_ready) begin
            parse_reader_byte('{req_func, req_rx_byte});
            items_taken++;
            tx_free = 1'b1;
         end
         if (tx_free) begin
            if (tx_gap > 0) begin
               tx_gap    <= tx_gap - 1;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req_valid   <= 1'b1;
               req_func    <= byte_queue[0].func;
               req_rx_byte <= byte_queue[0].rx_byte;
               void'(byte_queue.pop_front());
               if ($urandom_range(0, 99) < tx_gap_pct) begin
                  tx_gap <= gap_length();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side ready: random stalls plus one long hold-off
   int   rx_stall = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall  <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall  <= rx_stall - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
         rx_stall  <= gap_length() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // Result monitor: compare each transfer with the oldest prediction
   card_result_type mon_got;
   card_result_type mon_want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         mon_got.carries_id = rsp_carries_id;
         mon_got.card_ready = rsp_card_ready;
         mon_got.id_char    = rsp_id_char;
         mon_got.id_index   = rsp_id_index;
         mon_got.last       = rsp_last;
         results_seen++;
         if (due_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none actual %h", $time, mon_got);
         end else begin
            mon_want = due_results.pop_front();
            check_field("carries_id", mon_want.carries_id, mon_got.carries_id);
            check_field("card_ready", mon_want.card_ready, mon_got.card_ready);
            check_field("id_char", mon_want.id_char, mon_got.id_char);
            check_field("id_index", mon_want.id_index, mon_got.id_index);
            check_field("last", mon_want.last, mon_got.last);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send(input logic func, input logic [7:0] rx_byte);
      byte_queue.push_back('{func, rx_byte});
      items_queued++;
   endtask

   // Build one frame of the given kind around the current start byte and queue it
   task automatic send_frame(input frame_kind_type kind);
      logic [7:0] bytes[FRAME_BYTES];
      logic [7:0] xsum;
      int         count;
      int         pick;
      if (kind != FRM_FIXED) begin
         for (int k = 0; k < ID_LEN; k++) begin
            pick = $urandom_range(0, 3);
            if (kind == FRM_ODD_ID && pick == 0) begin
               frame_id[k] = 8'($urandom_range(0, 255));
            end else if (kind == FRM_ODD_ID && pick == 1) begin
               frame_id[k] = trk_start_byte;
            end else begin
               frame_id[k] = nibble_to_hex(4'($urandom_range(0, 15)));
            end
         end
      end
      xsum = id_xor(frame_id);
      bytes[0] = trk_start_byte;
      for (int k = 0; k < ID_LEN; k++) begin
         bytes[1 + k] = frame_id[k];
      end
      bytes[POS_SUM_HI] = nibble_to_hex(xsum[7:4]);
      bytes[POS_SUM_LO] = nibble_to_hex(xsum[3:0]);
      bytes[POS_STOP]   = STOP_VALUE;
      count = FRAME_BYTES;
      case (kind)
         FRM_BAD_SUM:  bytes[POS_SUM_LO] = nibble_to_hex(xsum[3:0] ^ 4'($urandom_range(1, 15)));
         FRM_BAD_STOP: bytes[POS_STOP] = STOP_VALUE ^ 8'($urandom_range(1, 255));
         FRM_RAW_SUM: begin
            bytes[POS_SUM_HI] = 8'($urandom_range(0, 255));
            bytes[POS_SUM_LO] = 8'($urandom_range(0, 255));
         end
         FRM_SHORT:    count = $urandom_range(2, FRAME_BYTES - 1);
         default: ;
      endcase
      for (int k = 0; k < count; k++) begin
         send(FUNC_BYTE, bytes[k]);
      end
   endtask

   // Wait until every item is taken and every result is in, then let the block settle
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (items_taken != items_queued || due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_byte(input logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      trk_start_byte = value;
   endtask

   task automatic run_random_phase(input logic [7:0] start_val, input int tx_pct,
                                   input int rx_pct);
      int base;
      int r;
      wait_idle();
      write_start_byte(start_val);
      tx_gap_pct   = tx_pct;
      rx_stall_pct = rx_pct;
      base = items_queued;
      while (items_queued - base < PHASE_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            if ($urandom_range(0, 99) < 40) begin
               send(FUNC_CLEAR, 8'($urandom_range(0, 255)));
            end
            send_frame(($urandom_range(0, 99) < 70) ? FRM_GOOD : FRM_ODD_ID);
         end else if (r < 65) begin
            send_frame(FRM_BAD_SUM);
         end else if (r < 72) begin
            send_frame(FRM_BAD_STOP);
         end else if (r < 78) begin
            send_frame(FRM_RAW_SUM);
         end else if (r < 86) begin
            send_frame(FRM_SHORT);
         end else if (r < 93) begin
            send(FUNC_CLEAR, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) send(FUNC_BYTE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Sequence: reset, directed frame, then random phases over several start bytes
   initial begin
      trk_in_frame   = 1'b0;
      trk_pos        = 4'd0;
      trk_card_ready = 1'b0;
      trk_start_byte = START_RESET;
      foreach (trk_store[k]) trk_store[k] = 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: clear, ignored extremes, one valid frame with digit and letter extremes
      write_start_byte(START_RESET);
      send(FUNC_CLEAR, 8'hFF);
      send(FUNC_BYTE, 8'h00);
      send(FUNC_BYTE, 8'hFF);
      frame_id = '{"0", "9", "A", "F", "5", "A", "3", "F", "9", "0"};
      send_frame(FRM_FIXED);
      send(FUNC_CLEAR, 8'h00);

      run_random_phase(START_RESET, 0, 0);
      run_random_phase(8'h00, 20, 20);
      run_random_phase(8'hFF, 50, 10);
      run_random_phase(STOP_VALUE, 10, 50);
      run_random_phase("0", 30, 30);
      run_random_phase(8'($urandom_range(0, 255)), 0, 40);
      wait_idle();

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
